[hw/rtl/lcd_pkg.sv]
// ----------------------------------------------------------------------------
// lcd_pkg
// Shared widths, constants, register map and types of the lane crossing
// detector.
// ----------------------------------------------------------------------------
package lcd_pkg;

  localparam int MAX_POINTS = 1024;
  localparam int Y_BITS     = 11;
  localparam int CNT_W      = $clog2(MAX_POINTS + 1);
  localparam int DIR_W      = 9;
  localparam int SIDE_W     = 2;
  localparam int LABEL_W    = 16;
  localparam int DATA_W     = 32;
  localparam int ADDR_W     = 4;
  localparam int REG_IDX_W  = 2;

  // side codes
  localparam logic [SIDE_W-1:0] SIDE_LEFT  = 2'd0;
  localparam logic [SIDE_W-1:0] SIDE_MID   = 2'd1;
  localparam logic [SIDE_W-1:0] SIDE_RIGHT = 2'd2;

  // walk phases
  localparam logic [1:0] PH_FIRST = 2'd0;
  localparam logic [1:0] PH_RUN   = 2'd1;
  localparam logic [1:0] PH_STOP  = 2'd2;

  // register map (word index)
  localparam logic [REG_IDX_W-1:0] REG_START_MIN = 2'd0;
  localparam logic [REG_IDX_W-1:0] REG_START_MAX = 2'd1;
  localparam logic [REG_IDX_W-1:0] REG_MAX_STEP  = 2'd2;

  localparam logic [DIR_W-1:0] RST_START_MIN = 9'd45;
  localparam logic [DIR_W-1:0] RST_START_MAX = 9'd135;
  localparam logic [DIR_W-1:0] RST_MAX_STEP  = 9'd30;

  // thresholds
  localparam int TURN_Y_MIN   = 220;
  localparam int TURN_JUMP    = 80;
  localparam int LWIN_LO      = 140;
  localparam int LWIN_HI      = 220;
  localparam int RWIN_HI      = 320;
  localparam int RWIN_LO      = 40;
  localparam int FLAT_HI      = 340;
  localparam int FLAT_LO      = 20;
  localparam int FLAT_MID_LO  = 160;
  localparam int FLAT_MID_HI  = 200;
  localparam int KEPT_Y_MIN   = 250;
  localparam int KEPT_CNT_MAX = 150;
  localparam int FULL_TURN    = 360;

  typedef struct packed {
    logic [DIR_W-1:0] start_min;
    logic [DIR_W-1:0] start_max;
    logic [DIR_W-1:0] max_step;
  } cfg_t;

  typedef struct packed {
    logic [SIDE_W-1:0]        side;
    logic                     has_point;
    logic [DIR_W-1:0]         direction;
    logic [Y_BITS-1:0]        point_y;
    logic signed [LABEL_W-1:0] label;
    logic                     end_of_frame;
  } item_t;

  typedef struct packed {
    logic [DIR_W-1:0]  dir;
    logic [Y_BITS-1:0] y;
  } point_t;

  typedef struct packed {
    logic             turn;
    logic [CNT_W-1:0] kept;
    logic             low_ok;
    logic             few;
  } side_stat_t;

  typedef struct packed {
    logic             crossing;
    logic             left_turn;
    logic             right_turn;
    logic             mid_horizontal;
    logic [CNT_W-1:0] left_kept;
    logic [CNT_W-1:0] right_kept;
  } result_t;

  function automatic logic [DIR_W-1:0] dir_dist(input logic [DIR_W-1:0] a,
                                                 input logic [DIR_W-1:0] b);
    return (a > b) ? (a - b) : (b - a);
  endfunction

endpackage

[hw/rtl/lcd_if.sv]
// ----------------------------------------------------------------------------
// lcd_if
// Valid/ready channels for lane point words and verdict words.
// ----------------------------------------------------------------------------
interface lcd_in_if;
  logic                               valid;
  logic                               ready;
  logic [lcd_pkg::SIDE_W-1:0]         side;
  logic                               has_point;
  logic [lcd_pkg::DIR_W-1:0]          direction;
  logic [lcd_pkg::Y_BITS-1:0]         point_y;
  logic signed [lcd_pkg::LABEL_W-1:0] label;
  logic                               end_of_frame;

  modport source (output valid, side, has_point, direction, point_y, label, end_of_frame,
                  input ready);
  modport sink (input valid, side, has_point, direction, point_y, label, end_of_frame,
                output ready);
endinterface

interface lcd_out_if;
  logic                      valid;
  logic                      ready;
  logic                      crossing;
  logic                      left_turn;
  logic                      right_turn;
  logic                      mid_horizontal;
  logic [lcd_pkg::CNT_W-1:0] left_kept;
  logic [lcd_pkg::CNT_W-1:0] right_kept;

  modport source (output valid, crossing, left_turn, right_turn, mid_horizontal,
                  left_kept, right_kept, input ready);
  modport sink (input valid, crossing, left_turn, right_turn, mid_horizontal,
                left_kept, right_kept, output ready);
endinterface

[hw/rtl/lcd_regs.sv]
// ----------------------------------------------------------------------------
// lcd_regs
// APB register file holding the drive-direction prefix settings.
// ----------------------------------------------------------------------------
module lcd_regs (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [lcd_pkg::ADDR_W-1:0]  paddr,
  input  logic [lcd_pkg::DATA_W-1:0]  pwdata,
  output logic [lcd_pkg::DATA_W-1:0]  prdata,
  output logic                        pready,
  output lcd_pkg::cfg_t               cfg
);

  lcd_pkg::cfg_t                      cfg_r;
  logic                               wr_en;
  logic [lcd_pkg::REG_IDX_W-1:0]      idx;
  logic [lcd_pkg::DIR_W-1:0]          wval;

  assign idx    = paddr[lcd_pkg::ADDR_W-1:2];
  assign wr_en  = psel && penable && pwrite;
  assign wval   = pwdata[lcd_pkg::DIR_W-1:0];
  assign pready = 1'b1;
  assign cfg    = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.start_min <= lcd_pkg::RST_START_MIN;
      cfg_r.start_max <= lcd_pkg::RST_START_MAX;
      cfg_r.max_step  <= lcd_pkg::RST_MAX_STEP;
    end else if (wr_en) begin
      unique case (idx)
        lcd_pkg::REG_START_MIN: cfg_r.start_min <= wval;
        lcd_pkg::REG_START_MAX: cfg_r.start_max <= wval;
        lcd_pkg::REG_MAX_STEP:  cfg_r.max_step  <= wval;
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      lcd_pkg::REG_START_MIN: prdata = lcd_pkg::DATA_W'(cfg_r.start_min);
      lcd_pkg::REG_START_MAX: prdata = lcd_pkg::DATA_W'(cfg_r.start_max);
      lcd_pkg::REG_MAX_STEP:  prdata = lcd_pkg::DATA_W'(cfg_r.max_step);
      default:                prdata = '0;
    endcase
  end

endmodule

[hw/rtl/lcd_side.sv]
// ----------------------------------------------------------------------------
// lcd_side
// Per side line tracker: turn walk and drive-direction prefix length/min row.
// ----------------------------------------------------------------------------
module lcd_side (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  take,
  input  logic                  clear,
  input  logic                  is_right,
  input  lcd_pkg::cfg_t         cfg,
  input  lcd_pkg::point_t       pt,
  output lcd_pkg::side_stat_t   stat
);

  logic [lcd_pkg::DIR_W-1:0]  walk_prev_r, walk_prev_nxt;
  logic [1:0]                 walk_phase_r, walk_phase_nxt;
  logic                       turn_r, turn_nxt;
  logic [lcd_pkg::DIR_W-1:0]  keep_prev_r, keep_prev_nxt;
  logic [1:0]                 keep_phase_r, keep_phase_nxt;
  logic [lcd_pkg::CNT_W-1:0]  cnt_r, cnt_nxt;
  logic [lcd_pkg::Y_BITS-1:0] min_y_r, min_y_nxt;

  logic [lcd_pkg::DIR_W-1:0]  walk_ref, walk_diff, keep_ref, keep_diff, step_lim;
  logic                       in_win, start_ok, cut;

  always_comb begin
    walk_ref  = (walk_phase_r == lcd_pkg::PH_FIRST) ? pt.dir : walk_prev_r;
    walk_diff = lcd_pkg::dir_dist(pt.dir, walk_ref);
    keep_ref  = (keep_phase_r == lcd_pkg::PH_FIRST) ? pt.dir : keep_prev_r;
    keep_diff = lcd_pkg::dir_dist(pt.dir, keep_ref);
    step_lim  = lcd_pkg::DIR_W'(lcd_pkg::FULL_TURN) - cfg.max_step;
    if (is_right) begin
      in_win = (pt.dir > lcd_pkg::DIR_W'(lcd_pkg::RWIN_HI)) ||
               (pt.dir < lcd_pkg::DIR_W'(lcd_pkg::RWIN_LO));
    end else begin
      in_win = (pt.dir > lcd_pkg::DIR_W'(lcd_pkg::LWIN_LO)) &&
               (pt.dir < lcd_pkg::DIR_W'(lcd_pkg::LWIN_HI));
    end
    start_ok = (pt.dir > cfg.start_min) && (pt.dir < cfg.start_max);
    cut = (keep_diff > cfg.max_step) ||
          (cfg.max_step > lcd_pkg::DIR_W'(lcd_pkg::FULL_TURN)) ||
          (keep_diff > step_lim);

    walk_prev_nxt  = walk_prev_r;
    walk_phase_nxt = walk_phase_r;
    turn_nxt       = turn_r;
    keep_prev_nxt  = keep_prev_r;
    keep_phase_nxt = keep_phase_r;
    cnt_nxt        = cnt_r;
    min_y_nxt      = min_y_r;

    if (take && (walk_phase_r != lcd_pkg::PH_STOP)) begin
      walk_phase_nxt = lcd_pkg::PH_RUN;
      walk_prev_nxt  = walk_ref;
      if (pt.y < lcd_pkg::Y_BITS'(lcd_pkg::TURN_Y_MIN)) begin
        walk_phase_nxt = lcd_pkg::PH_STOP;
      end else if ((walk_diff > lcd_pkg::DIR_W'(lcd_pkg::TURN_JUMP)) && in_win) begin
        turn_nxt       = 1'b1;
        walk_phase_nxt = lcd_pkg::PH_STOP;
      end else begin
        walk_prev_nxt = pt.dir;
      end
    end

    if (take && (keep_phase_r != lcd_pkg::PH_STOP)) begin
      if ((keep_phase_r == lcd_pkg::PH_FIRST) && !start_ok) begin
        keep_phase_nxt = lcd_pkg::PH_STOP;
      end else if (cut) begin
        keep_phase_nxt = lcd_pkg::PH_STOP;
      end else begin
        keep_phase_nxt = lcd_pkg::PH_RUN;
        keep_prev_nxt  = pt.dir;
        if ((cnt_r == '0) || (pt.y < min_y_r)) begin
          min_y_nxt = pt.y;
        end
        if (cnt_r < lcd_pkg::CNT_W'(lcd_pkg::MAX_POINTS)) begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
    end

    stat.turn   = turn_nxt;
    stat.kept   = cnt_nxt;
    stat.low_ok = (cnt_nxt != '0) && (min_y_nxt > lcd_pkg::Y_BITS'(lcd_pkg::KEPT_Y_MIN));
    stat.few    = cnt_nxt < lcd_pkg::CNT_W'(lcd_pkg::KEPT_CNT_MAX);
  end

  always_ff @(posedge clk) begin
    if (!rst_n || clear) begin
      walk_prev_r  <= '0;
      walk_phase_r <= lcd_pkg::PH_FIRST;
      turn_r       <= 1'b0;
      keep_prev_r  <= '0;
      keep_phase_r <= lcd_pkg::PH_FIRST;
      cnt_r        <= '0;
      min_y_r      <= '0;
    end else if (take) begin
      walk_prev_r  <= walk_prev_nxt;
      walk_phase_r <= walk_phase_nxt;
      turn_r       <= turn_nxt;
      keep_prev_r  <= keep_prev_nxt;
      keep_phase_r <= keep_phase_nxt;
      cnt_r        <= cnt_nxt;
      min_y_r      <= min_y_nxt;
    end
  end

endmodule

[hw/rtl/lane_crossing_detector.sv]
// ----------------------------------------------------------------------------
// lane_crossing_detector
// Streams lane points of left, mid and right lines and emits one crossing
// verdict word per frame-closing input word.
// ----------------------------------------------------------------------------
// Pipeline: two register stages (input reg, result reg); the verdict is valid
// from the result register once the frame-closing word leaves the input reg.
// Throughput: one input word per cycle; only a stalled verdict backs up input.
// Reset: synchronous, active low; clears frame state and pipeline valids and
// loads the register defaults (45, 135, 30).
module lane_crossing_detector (
  input  logic                        clk,
  input  logic                        rst_n,
  lcd_in_if.sink                      in_ch,
  lcd_out_if.source                   out_ch,
  input  logic                        cfg_psel,
  input  logic                        cfg_penable,
  input  logic                        cfg_pwrite,
  input  logic [lcd_pkg::ADDR_W-1:0]  cfg_paddr,
  input  logic [lcd_pkg::DATA_W-1:0]  cfg_pwdata,
  output logic [lcd_pkg::DATA_W-1:0]  cfg_prdata,
  output logic                        cfg_pready
);

  lcd_pkg::cfg_t        cfg;
  lcd_pkg::item_t       item_r;
  logic                 item_valid_r;
  lcd_pkg::result_t     res_r, res_nxt;
  logic                 out_valid_r, out_valid_nxt;
  logic                 advance, fire, clear, take_l, take_r, take_m;
  logic                 mid_flat_r, mid_flat_nxt, mid_pos_r, mid_pos_nxt, mid;
  lcd_pkg::point_t      pt;
  lcd_pkg::side_stat_t  stat_l, stat_r;
  logic [lcd_pkg::DIR_W-1:0] dir;

  lcd_regs u_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (cfg_psel),
    .penable (cfg_penable),
    .pwrite  (cfg_pwrite),
    .paddr   (cfg_paddr),
    .pwdata  (cfg_pwdata),
    .prdata  (cfg_prdata),
    .pready  (cfg_pready),
    .cfg     (cfg)
  );

  assign advance     = !out_valid_r || out_ch.ready;
  assign fire        = item_valid_r && advance;
  assign in_ch.ready = !item_valid_r || advance;
  assign clear       = fire && item_r.end_of_frame;
  assign take_l      = fire && item_r.has_point && (item_r.side == lcd_pkg::SIDE_LEFT);
  assign take_r      = fire && item_r.has_point && (item_r.side == lcd_pkg::SIDE_RIGHT);
  assign take_m      = fire && item_r.has_point && (item_r.side == lcd_pkg::SIDE_MID);
  assign pt.dir      = item_r.direction;
  assign pt.y        = item_r.point_y;
  assign dir         = item_r.direction;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      item_valid_r <= 1'b0;
    end else if (in_ch.ready) begin
      item_valid_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.ready && in_ch.valid) begin
      item_r.side         <= in_ch.side;
      item_r.has_point    <= in_ch.has_point;
      item_r.direction    <= in_ch.direction;
      item_r.point_y      <= in_ch.point_y;
      item_r.label        <= in_ch.label;
      item_r.end_of_frame <= in_ch.end_of_frame;
    end
  end

  lcd_side u_left (
    .clk      (clk),
    .rst_n    (rst_n),
    .take     (take_l),
    .clear    (clear),
    .is_right (1'b0),
    .cfg      (cfg),
    .pt       (pt),
    .stat     (stat_l)
  );

  lcd_side u_right (
    .clk      (clk),
    .rst_n    (rst_n),
    .take     (take_r),
    .clear    (clear),
    .is_right (1'b1),
    .cfg      (cfg),
    .pt       (pt),
    .stat     (stat_r)
  );

  always_comb begin
    mid_flat_nxt = mid_flat_r;
    mid_pos_nxt  = mid_pos_r;
    if (take_m) begin
      if ((dir > lcd_pkg::DIR_W'(lcd_pkg::FLAT_HI)) ||
          (dir < lcd_pkg::DIR_W'(lcd_pkg::FLAT_LO)) ||
          ((dir > lcd_pkg::DIR_W'(lcd_pkg::FLAT_MID_LO)) &&
           (dir < lcd_pkg::DIR_W'(lcd_pkg::FLAT_MID_HI)))) begin
        mid_flat_nxt = 1'b1;
      end
      mid_pos_nxt = (item_r.label != '0) && !item_r.label[lcd_pkg::LABEL_W-1];
    end
    mid = mid_flat_nxt && mid_pos_nxt;

    res_nxt.crossing       = stat_l.few && stat_r.few &&
                             ((mid && (stat_l.low_ok || stat_r.low_ok)) ||
                              (stat_l.turn && stat_r.turn && stat_l.low_ok && stat_r.low_ok));
    res_nxt.left_turn      = stat_l.turn;
    res_nxt.right_turn     = stat_r.turn;
    res_nxt.mid_horizontal = mid;
    res_nxt.left_kept      = stat_l.kept;
    res_nxt.right_kept     = stat_r.kept;
  end

  always_ff @(posedge clk) begin
    if (!rst_n || clear) begin
      mid_flat_r <= 1'b0;
      mid_pos_r  <= 1'b0;
    end else if (take_m) begin
      mid_flat_r <= mid_flat_nxt;
      mid_pos_r  <= mid_pos_nxt;
    end
  end

  always_comb begin
    priority if (fire) begin
      out_valid_nxt = item_r.end_of_frame;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (clear) begin
      res_r <= res_nxt;
    end
  end

  assign out_ch.valid          = out_valid_r;
  assign out_ch.crossing       = res_r.crossing;
  assign out_ch.left_turn      = res_r.left_turn;
  assign out_ch.right_turn     = res_r.right_turn;
  assign out_ch.mid_horizontal = res_r.mid_horizontal;
  assign out_ch.left_kept      = res_r.left_kept;
  assign out_ch.right_kept     = res_r.right_kept;

endmodule

[hw/rtl/lcd_checker.sv]
// ----------------------------------------------------------------------------
// lcd_checker
// Port-level assertions on the verdict stream of the lane crossing detector.
// ----------------------------------------------------------------------------
module lcd_checker (
  input logic                      clk,
  input logic                      rst_n,
  input logic                      out_valid,
  input logic                      out_ready,
  input logic                      crossing,
  input logic                      left_turn,
  input logic                      right_turn,
  input logic                      mid_horizontal,
  input logic [lcd_pkg::CNT_W-1:0] left_kept,
  input logic [lcd_pkg::CNT_W-1:0] right_kept
);

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(crossing) && $stable(left_kept) &&
                                $stable(right_kept) && $stable(left_turn) &&
                                $stable(right_turn) && $stable(mid_horizontal))
    else $error("verdict changed while stalled");

  a_rst: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("verdict valid after reset");

  a_small: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && crossing |->
      (left_kept < lcd_pkg::CNT_W'(lcd_pkg::KEPT_CNT_MAX)) &&
      (right_kept < lcd_pkg::CNT_W'(lcd_pkg::KEPT_CNT_MAX)))
    else $error("crossing with large prefix");

  a_turns: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && crossing && !mid_horizontal |-> left_turn && right_turn)
    else $error("crossing without mid line or both turns");

  a_sat: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (left_kept <= lcd_pkg::CNT_W'(lcd_pkg::MAX_POINTS)) &&
                  (right_kept <= lcd_pkg::CNT_W'(lcd_pkg::MAX_POINTS)))
    else $error("prefix count above saturation");

endmodule

bind lane_crossing_detector lcd_checker u_lcd_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .out_valid      (out_ch.valid),
  .out_ready      (out_ch.ready),
  .crossing       (out_ch.crossing),
  .left_turn      (out_ch.left_turn),
  .right_turn     (out_ch.right_turn),
  .mid_horizontal (out_ch.mid_horizontal),
  .left_kept      (out_ch.left_kept),
  .right_kept     (out_ch.right_kept)
);

[sim/testbench.sv]
// ----------------------------------------------------------------------------
// Lane crossing detector testbench
// Streams lane point words for the left, mid and right lines through the
// valid/ready input channel and checks every verdict word against a
// cycle-free predictor of the turn walks, drive-direction prefixes and mid
// line flags. The register settings are swept between phases over the APB
// port, with random idling on both channels and one long verdict hold-off.
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [lcd_pkg::SIDE_W-1:0] SIDE_NONE = 2'd3;
  localparam int LIMIT_CYCLES = 200000;
  localparam int HOLD_CYCLES  = 200;
  localparam int DRAIN_CYCLES = 4;

  class verdict_board;
    logic [lcd_pkg::DIR_W-1:0]  start_min, start_max, max_step;
    logic [lcd_pkg::DIR_W-1:0]  walk_prev [2];
    logic [1:0]                 walk_ph [2];
    bit                         turn [2];
    logic [lcd_pkg::DIR_W-1:0]  keep_prev [2];
    logic [1:0]                 keep_ph [2];
    logic [lcd_pkg::CNT_W-1:0]  kept [2];
    logic [lcd_pkg::Y_BITS-1:0] min_y [2];
    bit                         mid_flat, mid_pos;
    lcd_pkg::result_t           verdicts [$];
    int                         errors;

    function new();
      start_min = lcd_pkg::RST_START_MIN;
      start_max = lcd_pkg::RST_START_MAX;
      max_step  = lcd_pkg::RST_MAX_STEP;
      errors    = 0;
      clear_frame();
    endfunction

    function void clear_frame();
      for (int s = 0; s < 2; s++) begin
        walk_prev[s] = '0;
        walk_ph[s]   = lcd_pkg::PH_FIRST;
        turn[s]      = 1'b0;
        keep_prev[s] = '0;
        keep_ph[s]   = lcd_pkg::PH_FIRST;
        kept[s]      = '0;
        min_y[s]     = '0;
      end
      mid_flat = 1'b0;
      mid_pos  = 1'b0;
    endfunction

    function void set_reg(logic [lcd_pkg::REG_IDX_W-1:0] idx,
                          logic [lcd_pkg::DIR_W-1:0] value);
      case (idx)
        lcd_pkg::REG_START_MIN: start_min = value;
        lcd_pkg::REG_START_MAX: start_max = value;
        lcd_pkg::REG_MAX_STEP:  max_step  = value;
        default: ;
      endcase
    endfunction

    function void note_word(lcd_pkg::item_t w);
      int               s, dir, y, p, d, st;
      bit               in_win, go, mid, ly, ry, sizes_ok;
      lcd_pkg::result_t r;
      dir = w.direction;
      y   = w.point_y;
      if (w.has_point && (w.side == lcd_pkg::SIDE_LEFT || w.side == lcd_pkg::SIDE_RIGHT)) begin
        s = (w.side == lcd_pkg::SIDE_LEFT) ? 0 : 1;
        // turn walk
        if (walk_ph[s] != lcd_pkg::PH_STOP) begin
          if (walk_ph[s] == lcd_pkg::PH_FIRST) begin
            walk_prev[s] = w.direction;
            walk_ph[s]   = lcd_pkg::PH_RUN;
          end
          if (y < lcd_pkg::TURN_Y_MIN) begin
            walk_ph[s] = lcd_pkg::PH_STOP;
          end else begin
            in_win = (s == 0) ? (dir > lcd_pkg::LWIN_LO && dir < lcd_pkg::LWIN_HI)
                              : (dir > lcd_pkg::RWIN_HI || dir < lcd_pkg::RWIN_LO);
            p = walk_prev[s];
            d = (dir > p) ? dir - p : p - dir;
            if (d > lcd_pkg::TURN_JUMP && in_win) begin
              turn[s]    = 1'b1;
              walk_ph[s] = lcd_pkg::PH_STOP;
            end else begin
              walk_prev[s] = w.direction;
            end
          end
        end
        // drive-direction prefix
        if (keep_ph[s] != lcd_pkg::PH_STOP) begin
          go = 1'b1;
          if (keep_ph[s] == lcd_pkg::PH_FIRST) begin
            if (!(w.direction > start_min && w.direction < start_max)) begin
              keep_ph[s] = lcd_pkg::PH_STOP;
              go = 1'b0;
            end else begin
              keep_prev[s] = w.direction;
              keep_ph[s]   = lcd_pkg::PH_RUN;
            end
          end
          if (go) begin
            p  = keep_prev[s];
            d  = (dir > p) ? dir - p : p - dir;
            st = max_step;
            if (d > st || (lcd_pkg::FULL_TURN - st) < d) begin
              keep_ph[s] = lcd_pkg::PH_STOP;
            end else begin
              if (kept[s] == 0 || w.point_y < min_y[s]) min_y[s] = w.point_y;
              if (kept[s] < lcd_pkg::MAX_POINTS) kept[s] = kept[s] + 1'b1;
              keep_prev[s] = w.direction;
            end
          end
        end
      end else if (w.has_point && w.side == lcd_pkg::SIDE_MID) begin
        if (dir > lcd_pkg::FLAT_HI || dir < lcd_pkg::FLAT_LO ||
            (dir > lcd_pkg::FLAT_MID_LO && dir < lcd_pkg::FLAT_MID_HI))
          mid_flat = 1'b1;
        mid_pos = (w.label > 0);
      end
      if (w.end_of_frame) begin
        mid      = mid_flat && mid_pos;
        ly       = (kept[0] != 0) && (min_y[0] > lcd_pkg::KEPT_Y_MIN);
        ry       = (kept[1] != 0) && (min_y[1] > lcd_pkg::KEPT_Y_MIN);
        sizes_ok = (kept[0] < lcd_pkg::KEPT_CNT_MAX) && (kept[1] < lcd_pkg::KEPT_CNT_MAX);
        r.crossing       = sizes_ok && ((mid && (ly || ry)) ||
                                        (turn[0] && turn[1] && ly && ry));
        r.left_turn      = turn[0];
        r.right_turn     = turn[1];
        r.mid_horizontal = mid;
        r.left_kept      = kept[0];
        r.right_kept     = kept[1];
        verdicts = {verdicts, r};
        clear_frame();
      end
    endfunction

    function int pending();
      return verdicts.size();
    endfunction

    function void field_check(string name, int want, int got);
      if (want != got) begin
        $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
        errors++;
      end
    endfunction

    function void check_result(lcd_pkg::result_t got);
      lcd_pkg::result_t want;
      if (verdicts.size() == 0) begin
        $display("%0t: verdict with none expected, expected none, actual %p", $time, got);
        errors++;
        return;
      end
      want = verdicts.pop_front();
      field_check("crossing",       want.crossing,       got.crossing);
      field_check("left_turn",      want.left_turn,      got.left_turn);
      field_check("right_turn",     want.right_turn,     got.right_turn);
      field_check("mid_horizontal", want.mid_horizontal, got.mid_horizontal);
      field_check("left_kept",      want.left_kept,      got.left_kept);
      field_check("right_kept",     want.right_kept,     got.right_kept);
    endfunction
  endclass

  logic                       clk;
  logic                       rst_n;
  logic                       cfg_psel, cfg_penable, cfg_pwrite;
  logic [lcd_pkg::ADDR_W-1:0] cfg_paddr;
  logic [lcd_pkg::DATA_W-1:0] cfg_pwdata;
  logic [lcd_pkg::DATA_W-1:0] cfg_prdata;
  logic                       cfg_pready;

  lcd_in_if  in_ch ();
  lcd_out_if out_ch ();

  lane_crossing_detector u_top (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_ch       (in_ch),
    .out_ch      (out_ch),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  verdict_board sb;
  bit calm;
  bit hold_req;
  int sent;

  initial clk = 1'b0;
  always #5 clk = ~clk;

  function automatic lcd_pkg::item_t word(logic [lcd_pkg::SIDE_W-1:0] side, bit hp,
                                          int dir, int y, int label, bit eof);
    lcd_pkg::item_t w;
    w.side         = side;
    w.has_point    = hp;
    w.direction    = lcd_pkg::DIR_W'(dir);
    w.point_y      = lcd_pkg::Y_BITS'(y);
    w.label        = lcd_pkg::LABEL_W'(label);
    w.end_of_frame = eof;
    return w;
  endfunction

  function automatic lcd_pkg::item_t noise_word();
    return word(lcd_pkg::SIDE_W'($urandom_range(0, 3)), 1'($urandom_range(0, 1)),
                $urandom_range(0, 511), $urandom_range(0, 2047), $urandom,
                $urandom_range(0, 5) == 0);
  endfunction

  task automatic send_word(lcd_pkg::item_t w);
    if (!calm && $urandom_range(0, 7) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    in_ch.valid        <= 1'b1;
    in_ch.side         <= w.side;
    in_ch.has_point    <= w.has_point;
    in_ch.direction    <= w.direction;
    in_ch.point_y      <= w.point_y;
    in_ch.label        <= w.label;
    in_ch.end_of_frame <= w.end_of_frame;
    do @(posedge clk); while (!in_ch.ready);
    sb.note_word(w);
    if ((w.has_point && w.side != SIDE_NONE) || w.end_of_frame) sent++;
  endtask

  // clean lines keep row, start and step inside the prefix rules
  task automatic build_line(logic [lcd_pkg::SIDE_W-1:0] side, int n, bit clean,
                            ref lcd_pkg::item_t q[$]);
    int dir, st, y;
    st = (sb.max_step > 40) ? 40 : sb.max_step;
    if ((clean || $urandom_range(0, 3) != 0) && sb.start_max > sb.start_min + 1)
      dir = $urandom_range(sb.start_min + 1, sb.start_max - 1);
    else
      dir = $urandom_range(0, 359);
    for (int i = 0; i < n; i++) begin
      case (clean ? 9 : $urandom_range(0, 9))
        0:       y = $urandom_range(0, lcd_pkg::TURN_Y_MIN - 1);
        1:       y = $urandom_range(lcd_pkg::TURN_Y_MIN, lcd_pkg::KEPT_Y_MIN);
        default: y = $urandom_range(lcd_pkg::KEPT_Y_MIN + 1, 2047);
      endcase
      if (i > 0) begin
        case (clean ? 11 : $urandom_range(0, 11))
          0: begin
            if (side == lcd_pkg::SIDE_LEFT)
              dir = $urandom_range(lcd_pkg::LWIN_LO + 1, lcd_pkg::LWIN_HI - 1);
            else if ($urandom_range(0, 1)) dir = $urandom_range(lcd_pkg::RWIN_HI + 1, 359);
            else dir = $urandom_range(0, lcd_pkg::RWIN_LO - 1);
          end
          1: dir = $urandom_range(0, 511);
          default: begin
            dir = dir + $urandom_range(0, 2 * st) - st;
            if (clean) dir = (dir < 0) ? 0 : (dir > 359) ? 359 : dir;
            else dir = (dir + 720) % 360;
          end
        endcase
      end
      q = {q, word(side, 1'b1, dir, y, $urandom, 1'b0)};
    end
  endtask

  task automatic send_frame(int nl, int nr, int nm, bit clean);
    lcd_pkg::item_t lq[$], rq[$], mq[$], fr[$];
    int             dir, label;
    build_line(lcd_pkg::SIDE_LEFT, nl, clean, lq);
    build_line(lcd_pkg::SIDE_RIGHT, nr, clean, rq);
    for (int i = 0; i < nm; i++) begin
      if ($urandom_range(0, 1)) begin
        case ($urandom_range(0, 2))
          0:       dir = $urandom_range(0, lcd_pkg::FLAT_LO - 1);
          1:       dir = $urandom_range(lcd_pkg::FLAT_MID_LO + 1, lcd_pkg::FLAT_MID_HI - 1);
          default: dir = $urandom_range(lcd_pkg::FLAT_HI + 1, 359);
        endcase
      end else begin
        dir = $urandom_range(0, 359);
      end
      label = ($urandom_range(0, 5) == 0) ? 0 : $urandom;
      mq = {mq, word(lcd_pkg::SIDE_MID, 1'b1, dir, $urandom_range(0, 2047), label, 1'b0)};
    end
    while (lq.size() + rq.size() + mq.size() > 0) begin
      case ($urandom_range(0, 2))
        0:       if (lq.size() > 0) fr = {fr, lq.pop_front()};
        1:       if (rq.size() > 0) fr = {fr, rq.pop_front()};
        default: if (mq.size() > 0) fr = {fr, mq.pop_front()};
      endcase
    end
    if (fr.size() == 0 || $urandom_range(0, 3) == 0)
      fr = {fr, word(lcd_pkg::SIDE_W'($urandom_range(0, 3)), 1'b0, $urandom_range(0, 511),
                     $urandom_range(0, 2047), $urandom, 1'b1)};
    else
      fr[fr.size() - 1].end_of_frame = 1'b1;
    foreach (fr[i]) send_word(fr[i]);
  endtask

  task automatic run_random(int count);
    int goal;
    goal = sent + count;
    while (sent < goal) begin
      if ($urandom_range(0, 4) == 0)
        repeat ($urandom_range(1, 5)) send_word(noise_word());
      else
        send_frame($urandom_range(0, 12), $urandom_range(0, 12), $urandom_range(0, 4), 1'b0);
    end
  endtask

  task automatic settle();
    in_ch.valid <= 1'b0;
    while (sb.pending() > 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(logic [lcd_pkg::REG_IDX_W-1:0] idx,
                           logic [lcd_pkg::DIR_W-1:0] value);
    logic [lcd_pkg::DATA_W-1:0] rd;
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= {idx, 2'b00};
    cfg_pwdata  <= lcd_pkg::DATA_W'(value);
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    sb.set_reg(idx, value);
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    rd = cfg_prdata;
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    sb.field_check("register readback", value, rd[lcd_pkg::DIR_W-1:0]);
  endtask

  task automatic load_cfg(int lo, int hi, int step);
    write_reg(lcd_pkg::REG_START_MIN, lcd_pkg::DIR_W'(lo));
    write_reg(lcd_pkg::REG_START_MAX, lcd_pkg::DIR_W'(hi));
    write_reg(lcd_pkg::REG_MAX_STEP, lcd_pkg::DIR_W'(step));
  endtask

  // verdict receiver
  initial begin
    int stall_left;
    lcd_pkg::result_t got;
    stall_left = 0;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (out_ch.valid && out_ch.ready) begin
        got.crossing       = out_ch.crossing;
        got.left_turn      = out_ch.left_turn;
        got.right_turn     = out_ch.right_turn;
        got.mid_horizontal = out_ch.mid_horizontal;
        got.left_kept      = out_ch.left_kept;
        got.right_kept     = out_ch.right_kept;
        sb.check_result(got);
      end
      if (!rst_n) begin
        out_ch.ready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        if (stall_left == 0) out_ch.ready <= 1'b1;
      end else if (hold_req) begin
        hold_req = 1'b0;
        out_ch.ready <= 1'b0;
        stall_left = HOLD_CYCLES;
      end else if (!calm && $urandom_range(0, 7) == 0) begin
        out_ch.ready <= 1'b0;
        stall_left = $urandom_range(1, 3);
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  initial begin : watchdog
    int cycles;
    cycles = 0;
    while (cycles < LIMIT_CYCLES) begin
      @(posedge clk);
      cycles++;
    end
    $display("end of test: mismatches");
    $finish;
  end

  initial begin
    sb       = new();
    calm     = 1'b0;
    hold_req = 1'b0;
    sent     = 0;
    rst_n              <= 1'b0;
    cfg_psel           <= 1'b0;
    cfg_penable        <= 1'b0;
    cfg_pwrite         <= 1'b0;
    cfg_paddr          <= '0;
    cfg_pwdata         <= '0;
    in_ch.valid        <= 1'b0;
    in_ch.side         <= lcd_pkg::SIDE_LEFT;
    in_ch.has_point    <= 1'b0;
    in_ch.direction    <= '0;
    in_ch.point_y      <= '0;
    in_ch.label        <= '0;
    in_ch.end_of_frame <= 1'b0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // both turns with a flat, positively labeled mid line
    send_word(word(lcd_pkg::SIDE_LEFT,  1, 90,  300, 1,  0));
    send_word(word(lcd_pkg::SIDE_RIGHT, 1, 90,  400, 1,  0));
    send_word(word(lcd_pkg::SIDE_LEFT,  1, 95,  300, -1, 0));
    send_word(word(lcd_pkg::SIDE_RIGHT, 1, 100, 400, 0,  0));
    send_word(word(lcd_pkg::SIDE_MID,   1, 10,  500, 5,  0));
    send_word(word(lcd_pkg::SIDE_LEFT,  1, 190, 300, 0,  0));
    send_word(word(lcd_pkg::SIDE_RIGHT, 1, 350, 400, 0,  0));
    send_word(word(lcd_pkg::SIDE_LEFT,  0, 0,   0,   0,  1));
    // field extremes, negative last mid label, unused side closes the frame
    send_word(word(lcd_pkg::SIDE_LEFT,  1, 134, 0,    32767,  0));
    send_word(word(lcd_pkg::SIDE_MID,   1, 180, 100,  32767,  0));
    send_word(word(lcd_pkg::SIDE_MID,   1, 511, 100,  -32768, 0));
    send_word(word(lcd_pkg::SIDE_RIGHT, 1, 46,  2047, -32768, 0));
    send_word(word(SIDE_NONE,           1, 511, 2047, -1,     1));
    // empty frame
    send_word(word(lcd_pkg::SIDE_MID, 0, 0, 0, 0, 1));
    // start on window edges, zero mid label, step right at the limit
    send_word(word(lcd_pkg::SIDE_LEFT,  0, 511, 2047, -1, 0));
    send_word(word(lcd_pkg::SIDE_LEFT,  1, 45,  300, 0, 0));
    send_word(word(lcd_pkg::SIDE_LEFT,  1, 135, 300, 0, 0));
    send_word(word(lcd_pkg::SIDE_MID,   1, 165, 300, 0, 0));
    send_word(word(lcd_pkg::SIDE_RIGHT, 1, 134, 260, 1, 0));
    send_word(word(lcd_pkg::SIDE_RIGHT, 1, 104, 255, 1, 0));
    send_word(word(lcd_pkg::SIDE_RIGHT, 1, 73,  251, 1, 0));
    send_word(word(lcd_pkg::SIDE_MID,   1, 199, 300, 1, 1));
    run_random(80);

    settle();
    load_cfg(0, 359, 359);
    run_random(40);
    hold_req = 1'b1;
    run_random(50);

    settle();
    load_cfg(359, 0, 0);
    run_random(40);

    settle();
    load_cfg(20, 300, 200);
    run_random(40);

    settle();
    load_cfg(10, 200, 400);
    send_word(word(lcd_pkg::SIDE_LEFT, 1, 90, 300, 1, 1));
    run_random(20);

    settle();
    load_cfg(lcd_pkg::RST_START_MIN, lcd_pkg::RST_START_MAX, lcd_pkg::RST_MAX_STEP);
    send_frame(149, 150, 2, 1'b1);
    run_random(40);
    calm = 1'b1;
    run_random(40);

    settle();
    if (sb.errors == 0)
      $display("end of test: clean");
    else
      $display("end of test: mismatches");
    $finish;
  end

endmodule
